// ===== hw/rtl/rwsr_pkg.sv =====
// Package for the record wage sort and report block.
// Holds shared types, op and result codes, and the date check function.
package rwsr_pkg;

   localparam int MaxRecordsDefault = 64;

   typedef enum logic [1:0] {
      OP_LOAD   = 2'd0,
      OP_REPORT = 2'd1,
      OP_CLEAR  = 2'd2,
      OP_NONE   = 2'd3
   } op_type;

   typedef enum logic [2:0] {
      KIND_LOADED  = 3'd0,
      KIND_BADDATE = 3'd1,
      KIND_FULL    = 3'd2,
      KIND_ENTRY   = 3'd3,
      KIND_EMPTY   = 3'd4
   } kind_type;

   typedef struct packed {
      logic [1:0]  op;
      logic [15:0] units;
      logic [15:0] unit_price;
      logic [4:0]  birth_day;
      logic [3:0]  birth_month;
      logic [13:0] birth_year;
   } req_type;

   typedef struct packed {
      logic [2:0]  kind;
      logic [5:0]  rank;
      logic [5:0]  record_index;
      logic [31:0] wage;
      logic [37:0] total_wage;
      logic [5:0]  lowest_wage_index;
      logic [5:0]  oldest_index;
      logic        last;
   } rsp_type;

   // classified command passed from front to back
   typedef struct packed {
      op_type      op;
      logic        date_ok;
      logic [31:0] wage;
      logic [22:0] birth;   // year, month, day: compares as a date
   } cmd_type;

   typedef enum logic [2:0] {
      ST_IDLE, ST_SORT, ST_EMIT, ST_SINGLE
   } state_type;

   function automatic logic date_valid(logic [4:0] d, logic [3:0] m, logic [13:0] y);
      logic        leap;
      logic [4:0]  len;
      logic [26:0] prod;
      logic [7:0]  q100;
      logic [13:0] rem100;
      begin
         // year / 100 by reciprocal multiply, exact over the whole 14-bit range
         prod   = 27'(y) * 27'(13'd5243);
         q100   = prod[26:19];
         rem100 = y - (14'(q100) * 14'd100);
         // century years are leap only when the century count divides by 4
         leap = (rem100 == 14'd0) ? (q100[1:0] == 2'd0) : (y[1:0] == 2'd0);
         case (m)
            4'd2:                      len = leap ? 5'd29 : 5'd28;
            4'd4, 4'd6, 4'd9, 4'd11:  len = 5'd30;
            default:                   len = 5'd31;
         endcase
         date_valid = (m >= 4'd1) && (m <= 4'd12) && (d >= 5'd1) && (d <= len);
      end
   endfunction

endpackage

// ===== hw/rtl/rwsr_req_if.sv =====
// Valid/ready channel interfaces for requests and results.
// Depends on rwsr_pkg for payload types.
interface rwsr_req_if;
   logic             valid;
   logic             ready;
   rwsr_pkg::req_type data;
   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

interface rwsr_rsp_if;
   logic             valid;
   logic             ready;
   rwsr_pkg::rsp_type data;
   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

// ===== hw/rtl/rwsr_front.sv =====
// Front end: accepts requests, checks the date and forms the wage product.
// Depends on rwsr_pkg; holds a two-entry command queue.
module rwsr_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   output logic              in_ready,
   input  rwsr_pkg::req_type in_data,
   output logic              cmd_valid,
   input  logic              cmd_ready,
   output rwsr_pkg::cmd_type cmd_data
);
   rwsr_pkg::cmd_type q_ff [2];
   rwsr_pkg::cmd_type q_in;
   logic [1:0] cnt_ff, cnt_in;
   logic       rd_ff, wr_ff;
   logic       push, pop;

   assign in_ready  = (cnt_ff != 2'd2);
   assign push      = in_valid && in_ready && (in_data.op != rwsr_pkg::OP_NONE);
   assign cmd_valid = (cnt_ff != 2'd0);
   assign pop       = cmd_valid && cmd_ready;
   assign cmd_data  = q_ff[rd_ff];

   always_comb begin
      q_in.op      = rwsr_pkg::op_type'(in_data.op);
      q_in.date_ok = rwsr_pkg::date_valid(in_data.birth_day, in_data.birth_month,
                                          in_data.birth_year);
      q_in.wage    = in_data.units * in_data.unit_price;
      q_in.birth   = {in_data.birth_year, in_data.birth_month, in_data.birth_day};
      cnt_in = cnt_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (push) q_ff[wr_ff] <= q_in;
      if (reset) begin
         cnt_ff <= '0; rd_ff <= 1'b0; wr_ff <= 1'b0;
      end else begin
         cnt_ff <= cnt_in;
         if (push) wr_ff <= ~wr_ff;
         if (pop)  rd_ff <= ~rd_ff;
      end
   end

   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff != 2'd3) else $error("queue count overflow");
   a_no_push_full: assert property (@(posedge clock) disable iff (reset)
      cnt_ff == 2'd2 |-> !push) else $error("push into full queue");
   a_no_pop_empty: assert property (@(posedge clock) disable iff (reset)
      cnt_ff == 2'd0 |-> !pop) else $error("pop from empty queue");
endmodule

// ===== hw/rtl/rwsr_back.sv =====
// Back end: running summary, insertion sort and result output.
// Depends on rwsr_pkg; takes classified commands from the front queue.
module rwsr_back #(
   parameter int MAX_RECORDS = rwsr_pkg::MaxRecordsDefault
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              cmd_valid,
   output logic              cmd_ready,
   input  rwsr_pkg::cmd_type cmd_data,
   output logic              out_valid,
   input  logic              out_ready,
   output rwsr_pkg::rsp_type out_data
);
   localparam int IW = (MAX_RECORDS > 1) ? $clog2(MAX_RECORDS) : 1;
   localparam int CW = $clog2(MAX_RECORDS + 1);

   // sorted order list of load indices: shift cells
   logic [IW-1:0] ord_ff [MAX_RECORDS];
   logic [31:0]   ordw_ff [MAX_RECORDS];

   logic [CW-1:0] count_ff, count_in;
   logic [37:0]   total_ff, total_in;
   logic [IW-1:0] low_ff, low_in, old_ff, old_in;
   logic [31:0]   loww_ff, loww_in;
   logic [22:0]   oldb_ff, oldb_in;
   rwsr_pkg::state_type st_ff, st_in;
   logic [CW-1:0] ptr_ff, ptr_in;
   rwsr_pkg::rsp_type rsp_ff, rsp_in;
   logic          ov_ff, ov_in;
   logic          take, do_load, insert, rotate;

   // output register frees when empty or being taken
   logic oslot;
   assign oslot     = !ov_ff || out_ready;
   assign out_valid = ov_ff;
   assign out_data  = rsp_ff;
   assign cmd_ready = (st_ff == rwsr_pkg::ST_IDLE) && oslot;
   assign take      = cmd_valid && cmd_ready;
   assign do_load   = take && cmd_data.op == rwsr_pkg::OP_LOAD && cmd_data.date_ok
                      && (count_ff < CW'(MAX_RECORDS));
   assign insert    = do_load;
   assign rotate    = (st_ff == rwsr_pkg::ST_EMIT) && oslot;

   always_comb begin
      st_in = st_ff; ptr_in = ptr_ff; rsp_in = rsp_ff; ov_in = ov_ff && !out_ready;
      count_in = count_ff; total_in = total_ff; low_in = low_ff; old_in = old_ff;
      loww_in = loww_ff; oldb_in = oldb_ff;
      unique case (st_ff)
         rwsr_pkg::ST_IDLE: begin
            if (take) begin
               rsp_in = '0;
               rsp_in.last = 1'b1;
               rsp_in.total_wage = total_ff;
               rsp_in.lowest_wage_index = 6'(low_ff);
               rsp_in.oldest_index = 6'(old_ff);
               ov_in = 1'b1;
               case (cmd_data.op)
                  rwsr_pkg::OP_LOAD: begin
                     if (!cmd_data.date_ok) rsp_in.kind = rwsr_pkg::KIND_BADDATE;
                     else if (!do_load)     rsp_in.kind = rwsr_pkg::KIND_FULL;
                     else begin
                        rsp_in.kind = rwsr_pkg::KIND_LOADED;
                        rsp_in.record_index = 6'(count_ff);
                        rsp_in.wage = cmd_data.wage;
                        total_in = total_ff + 38'(cmd_data.wage);
                        if (count_ff == '0 || cmd_data.wage < loww_ff) begin
                           low_in = IW'(count_ff); loww_in = cmd_data.wage;
                        end
                        if (count_ff == '0 || cmd_data.birth < oldb_ff) begin
                           old_in = IW'(count_ff); oldb_in = cmd_data.birth;
                        end
                        count_in = count_ff + 1'b1;
                        rsp_in.total_wage = total_in;
                        rsp_in.lowest_wage_index = 6'(low_in);
                        rsp_in.oldest_index = 6'(old_in);
                     end
                  end
                  rwsr_pkg::OP_REPORT: begin
                     if (count_ff == '0) begin
                        rsp_in = '0; rsp_in.kind = rwsr_pkg::KIND_EMPTY;
                        rsp_in.last = 1'b1;
                     end else begin
                        ov_in = ov_ff && !out_ready;
                        ptr_in = '0;
                        st_in = rwsr_pkg::ST_EMIT;
                     end
                  end
                  default: begin
                     rsp_in = '0; rsp_in.kind = rwsr_pkg::KIND_EMPTY;
                     rsp_in.last = 1'b1;
                     count_in = '0; total_in = '0; low_in = '0; old_in = '0;
                  end
               endcase
            end
         end
         rwsr_pkg::ST_EMIT: begin
            // the head cell holds the next entry; the cells rotate behind it
            if (oslot) begin
               rsp_in.kind = rwsr_pkg::KIND_ENTRY;
               rsp_in.rank = 6'(ptr_ff);
               rsp_in.record_index = 6'(ord_ff[0]);
               rsp_in.wage = ordw_ff[0];
               rsp_in.total_wage = total_ff;
               rsp_in.lowest_wage_index = 6'(low_ff);
               rsp_in.oldest_index = 6'(old_ff);
               rsp_in.last = (ptr_ff + 1'b1 == count_ff);
               ov_in = 1'b1;
               ptr_in = ptr_ff + 1'b1;
               if (ptr_ff + 1'b1 == count_ff) st_in = rwsr_pkg::ST_IDLE;
            end
         end
         default: st_in = rwsr_pkg::ST_IDLE;
      endcase
   end

   // insertion into sorted cells: every cell with wage strictly above the new
   // one shifts up, the first such cell (or the tail) takes the new record
   logic [MAX_RECORDS-1:0] gt;
   always_comb begin
      for (int k = 0; k < MAX_RECORDS; k++)
         gt[k] = (CW'(k) < count_ff) && (ordw_ff[k] > cmd_data.wage);
   end

   always_ff @(posedge clock) begin
      if (insert) begin
         for (int k = 0; k < MAX_RECORDS; k++) begin
            if (gt[k]) begin
               if (k + 1 < MAX_RECORDS) begin
                  ord_ff[(k + 1) % MAX_RECORDS]  <= ord_ff[k];
                  ordw_ff[(k + 1) % MAX_RECORDS] <= ordw_ff[k];
               end
            end
            if ((k == 0 || !gt[(k + MAX_RECORDS - 1) % MAX_RECORDS])
                && (gt[k] || CW'(k) == count_ff)) begin
               ord_ff[k]  <= IW'(count_ff);
               ordw_ff[k] <= cmd_data.wage;
            end
         end
      end else if (rotate) begin
         // advance the stored cells by one; the head wraps to the tail, so a
         // full report leaves the cells in their original order
         for (int k = 0; k < MAX_RECORDS; k++) begin
            if (CW'(k + 1) == count_ff) begin
               ord_ff[k]  <= ord_ff[0];
               ordw_ff[k] <= ordw_ff[0];
            end else if (k + 1 < MAX_RECORDS && CW'(k + 1) < count_ff) begin
               ord_ff[k]  <= ord_ff[(k + 1) % MAX_RECORDS];
               ordw_ff[k] <= ordw_ff[(k + 1) % MAX_RECORDS];
            end
         end
      end
      rsp_ff <= rsp_in;
      total_ff <= total_in; low_ff <= low_in; old_ff <= old_in;
      loww_ff <= loww_in; oldb_ff <= oldb_in; ptr_ff <= ptr_in;
      if (reset) begin
         st_ff <= rwsr_pkg::ST_IDLE; ov_ff <= 1'b0; count_ff <= '0;
         total_ff <= '0; low_ff <= '0; old_ff <= '0;
      end else begin
         st_ff <= st_in; ov_ff <= ov_in; count_ff <= count_in;
      end
   end

   a_count_max: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(MAX_RECORDS)) else $error("record count overflow");
   a_emit_nonempty: assert property (@(posedge clock) disable iff (reset)
      st_ff == rwsr_pkg::ST_EMIT |-> count_ff != '0) else $error("emit with empty store");
   a_hold_out: assert property (@(posedge clock) disable iff (reset)
      ov_ff && !out_ready |=> ov_ff && $stable(rsp_ff)) else $error("result dropped");
endmodule

// ===== hw/rtl/record_wage_sort_and_report.sv =====
// Top level of the record wage sort and report block.
// Depends on rwsr_pkg, the channel interfaces, rwsr_front and rwsr_back.
//
// Channels: req (op, units, unit_price, birth date) and rsp (one result per
// load, clear or empty report, else one per stored record), both valid/ready.
// A request is accepted when req valid and ready are both high.
// Front end checks the date and forms the 32-bit wage, and queues the
// classified request in a two-entry queue. Back end keeps the running total,
// lowest-wage and oldest indices and a list of cells held in wage order:
// a load inserts by shifting the larger cells up, so equal wages stay in
// load order; a report rotates the cells through the head.
// A load or clear result passes through the command queue and then the
// output register. Throughput: one load or clear per cycle while the
// receiver takes results; a report of N records first turns the back end
// round into its emit state, then gives N sorted entries at one per cycle
// while the receiver takes them.
// Reset empties the store and the queue; the cell contents are not cleared.
// When the receiver stalls, the result holds in the output register, the
// back end stops and the queue fills, after which req ready drops.
// Unused op codes are dropped without a result.
module record_wage_sort_and_report #(
   parameter int MAX_RECORDS = rwsr_pkg::MaxRecordsDefault
) (
   input logic        clock,
   input logic        reset,
   rwsr_req_if.sink   req,
   rwsr_rsp_if.source rsp
);
   logic              cmd_valid, cmd_ready;
   rwsr_pkg::cmd_type cmd_data;

   rwsr_front u_front (
      .clock, .reset,
      .in_valid(req.valid), .in_ready(req.ready), .in_data(req.data),
      .cmd_valid, .cmd_ready, .cmd_data
   );

   rwsr_back #(.MAX_RECORDS(MAX_RECORDS)) u_back (
      .clock, .reset,
      .cmd_valid, .cmd_ready, .cmd_data,
      .out_valid(rsp.valid), .out_ready(rsp.ready), .out_data(rsp.data)
   );
endmodule
